/* sv/rgbhsi_pkg.sv */
// Package: shared widths, constants and the CORDIC angle table.
`timescale 1ns / 1ps
package rgbhsi_pkg;
  localparam int HUE_FRAC_BITS_DEF = 13;
  localparam int ANG_FRAC = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT3_Q16 = 113512;
  localparam int PI_Q24 = 52707179;
  localparam int TWO_PI_Q24 = 105414357;
  // CORDIC vector width: |x|,|y| < 2^26 grows by about 1.65
  localparam int CW = 30;
  localparam int ZW = 28;
  // saturation numerator reaches 510*2^16 + 510
  localparam int SATW = 26;

  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [ZW-1:0] ang_t;

  // Per-item side data that travels alongside the CORDIC
  typedef struct packed {
    logic       grey;
    logic       gb_zero;
    logic       xv_pos;
    logic       mirror;
    logic [9:0] sum;
    logic [7:0] mn;
  } side_t;

  function automatic ang_t atan_q24(input int i);
    ang_t t;
    case (i)
      0: t = 28'd13176795;  1: t = 28'd7778716;  2: t = 28'd4110060;
      3: t = 28'd2086331;   4: t = 28'd1047214;  5: t = 28'd524117;
      6: t = 28'd262123;    7: t = 28'd131069;
      default: t = ang_t'(28'd1 << (ANG_FRAC - i));
    endcase
    return t;
  endfunction
endpackage

/* sv/rgbhsi_cordic_stage.sv */
// One vectoring CORDIC iteration with a register behind it.
`timescale 1ns / 1ps
module rgbhsi_cordic_stage import rgbhsi_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  vin,
  input  cvec_t xin,
  input  cvec_t yin,
  input  ang_t  zin,
  input  side_t sin,
  output logic  vout,
  output cvec_t xout,
  output cvec_t yout,
  output ang_t  zout,
  output side_t sout
);
  cvec_t xs, ys;
  assign xs = xin >>> STEP;
  assign ys = yin >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else vout <= vin;
    sout <= sin;
    if (!yin[CW-1]) begin
      xout <= xin + ys;
      yout <= yin - xs;
      zout <= zin + atan_q24(STEP);
    end else begin
      xout <= xin - ys;
      yout <= yin + xs;
      zout <= zin - atan_q24(STEP);
    end
  end
endmodule

/* sv/rgbhsi_sat_div.sv */
// Pipelined restoring divider for saturation, one quotient bit per stage.
`timescale 1ns / 1ps
module rgbhsi_sat_div import rgbhsi_pkg::*; (
  input  logic            clk,
  input  logic [SATW-1:0] num,
  input  logic [10:0]     den,
  output logic [15:0]     quo
);
  // quotient < 2^16 so 16 stages; remainder kept 12 bits
  localparam int QB = 16;
  logic [SATW-1:0] n [QB+1];
  logic [11:0]     r [QB+1];
  logic [QB-1:0]   q [QB+1];
  logic [10:0]     d [QB+1];
  assign n[0] = num;
  assign r[0] = 12'(num >> QB);
  assign q[0] = '0;
  assign d[0] = den;
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [12:0] t;
    logic [12:0] diff;
    assign t = {r[i], n[i][QB-1-i]};
    assign diff = t - {2'b0, d[i]};
    always_ff @(posedge clk) begin
      n[i+1] <= n[i];
      d[i+1] <= d[i];
      if (!diff[12]) begin
        r[i+1] <= diff[11:0];
        q[i+1] <= {q[i][QB-2:0], 1'b1};
      end else begin
        r[i+1] <= t[11:0];
        q[i+1] <= {q[i][QB-2:0], 1'b0};
      end
    end
  end
  assign quo = q[QB];
endmodule

/* sv/rgb_to_hsi_pixel.sv */
// Top level: RGB to HSI pixel conversion pipeline.
// Channel  | Ports                                   | Transfer
// input    | red_in green_in blue_in                 | start && !busy
// result   | hue_out saturation_out intensity_out    | done, one cycle
// One pixel enters every cycle; busy is always low.
// The pipeline has one setup stage, 24 CORDIC stages and two output stages.
// The 24-step CORDIC chain sets the latency; the divider runs alongside it.
// Synchronous reset clears the valid bits only.
// The receiver cannot stall, so nothing ever holds inside the pipeline.
`timescale 1ns / 1ps
module rgb_to_hsi_pixel import rgbhsi_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        done,
  output logic [15:0] hue_out,
  output logic [15:0] saturation_out,
  output logic [15:0] intensity_out
);
  localparam int SH = ANG_FRAC - HUE_FRAC_BITS;
  // divider input register plus 16 quotient stages end with the CORDIC chain
  localparam int SAT_TAP = CORDIC_STEPS - 17;
  assign busy = 1'b0;

  // stage 0: setup
  logic [9:0] sum;
  logic [7:0] mn;
  logic signed [10:0] xv;
  logic [7:0] gb;
  side_t s0;
  cvec_t x0, y0;
  ang_t z0;
  always_comb begin
    sum = 10'(red_in) + 10'(green_in) + 10'(blue_in);
    mn = red_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    xv = 11'(signed'({3'b0, red_in}) * 2) - signed'({3'b0, green_in})
       - signed'({3'b0, blue_in});
    gb = (green_in >= blue_in) ? green_in - blue_in : blue_in - green_in;
    s0.grey = (red_in == green_in) && (green_in == blue_in);
    s0.gb_zero = (gb == 8'd0);
    s0.xv_pos = !xv[10] && (xv != 11'sd0);
    s0.mirror = blue_in > green_in;
    s0.sum = sum;
    s0.mn = mn;
  end

  logic  v [CORDIC_STEPS+1];
  cvec_t x [CORDIC_STEPS+1];
  cvec_t y [CORDIC_STEPS+1];
  ang_t  z [CORDIC_STEPS+1];
  side_t s [CORDIC_STEPS+1];

  always_comb begin
    cvec_t xa, ya;
    xa = CW'(xv) <<< 16;
    ya = CW'(gb) * CW'(SQRT3_Q16);
    if (xv[10]) begin
      x0 = ya; y0 = -xa; z0 = ang_t'(PI_Q24 / 2);
    end else begin
      x0 = xa; y0 = ya; z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= start;
    x[0] <= x0; y[0] <= y0; z[0] <= z0; s[0] <= s0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rgbhsi_cordic_stage #(.STEP(i)) u_stage (
      .clk, .rst, .vin(v[i]), .xin(x[i]), .yin(y[i]), .zin(z[i]), .sin(s[i]),
      .vout(v[i+1]), .xout(x[i+1]), .yout(y[i+1]), .zout(z[i+1]), .sout(s[i+1])
    );
  end

  // saturation divider alongside: (2*(sum-3mn)*32768 + sum) / (2*sum)
  logic [SATW-1:0] sat_num;
  logic [10:0] sat_den;
  logic [15:0] sat_q;
  always_ff @(posedge clk) begin
    sat_num <= (SATW'(s[SAT_TAP].sum) - SATW'(s[SAT_TAP].mn) * SATW'(3)) * SATW'(65536)
             + SATW'(s[SAT_TAP].sum);
    sat_den <= {s[SAT_TAP].sum, 1'b0};
  end
  rgbhsi_sat_div u_div (.clk, .num(sat_num), .den(sat_den), .quo(sat_q));

  // stage 25: angle select, clamp, mirror
  ang_t h;
  side_t s25;
  logic v25;
  logic [15:0] sat25;
  always_ff @(posedge clk) begin
    ang_t th;
    if (rst) v25 <= 1'b0;
    else v25 <= v[CORDIC_STEPS];
    s25 <= s[CORDIC_STEPS];
    sat25 <= sat_q;
    if (s[CORDIC_STEPS].gb_zero)
      th = s[CORDIC_STEPS].xv_pos ? ang_t'(0) : ang_t'(PI_Q24);
    else if (z[CORDIC_STEPS][ZW-1]) th = '0;
    else if (z[CORDIC_STEPS] > ang_t'(PI_Q24)) th = ang_t'(PI_Q24);
    else th = z[CORDIC_STEPS];
    if (s[CORDIC_STEPS].grey) h <= '0;
    else if (s[CORDIC_STEPS].mirror) h <= ang_t'(TWO_PI_Q24) - th;
    else h <= th;
  end

  // stage 26: hue rounding and clamp, saturation output, intensity
  always_ff @(posedge clk) begin
    logic [ZW:0] hr;
    logic [19:0] inum;
    if (rst) done <= 1'b0;
    else done <= v25;
    hr = ({1'b0, h} + (ZW+1)'(1 << (SH - 1))) >> SH;
    hue_out <= (hr > (ZW+1)'(16'hFFFF)) ? 16'hFFFF : hr[15:0];
    saturation_out <= (s25.sum == 10'd0) ? 16'd0 : sat25;
    // (sum*512+3)/6 = floor((sum*256+1)/3), via reciprocal 174763/2^19
    inum = 20'(s25.sum) * 20'd256 + 20'd1;
    intensity_out <= 16'((36'(inum) * 36'd174763) >> 19);
  end

  property p_done_follows;
    @(posedge clk) disable iff (rst) v25 |=> done;
  endproperty
  a_done_follows: assert property (p_done_follows) else $error("lost result");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy high");
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> saturation_out <= 16'd32768) else $error("saturation range");
endmodule
